// ===== hdl/bop_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bop_pkg : shared types and constants of the binomial option pricer
// Fixed-point constants and the controller/datapath command and status types.
// ----------------------------------------------------------------------------
package bop_pkg;

   localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
   localparam logic [31:0] SAT32   = 32'hFFFF_FFFF;
   localparam logic [10:0] STEPS_RESET = 11'd256;

   // datapath operation selected by the controller
   typedef enum logic [2:0] {
      OP_NONE  = 3'd0,
      OP_LOAD  = 3'd1,   // capture the beat, seed power[0]
      OP_POW   = 3'd2,   // one power of up and down
      OP_TERM  = 3'd3,   // one terminal node
      OP_BACK  = 3'd4    // one induction node
   } op_type;

   // controller to datapath
   typedef struct packed {
      op_type      op;
      logic [12:0] idx;    // node / power index i
      logic [12:0] lvl;    // layer t
      logic        first;  // first cycle of a node (issue reads)
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic node_done;
   } stat_type;

   // saturating truncating Q30 product
   function automatic logic [32:0] mul_q30(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] r;
      r = 64'(a) * 64'(b);
      if (r[63:62] != 2'b00) return {1'b1, SAT32};
      return {1'b0, r[61:30]};
   endfunction

   function automatic logic [31:0] payoff(input logic [31:0] pr, input logic [31:0] k,
                                          input logic call);
      if (call) return (pr > k) ? pr - k : 32'd0;
      return (k > pr) ? k - pr : 32'd0;
   endfunction

endpackage

// ===== hdl/bop_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bop_datapath : lattice memories and node arithmetic
// Holds the power tables and node values, and works one node at a time
// through a registered multiply sequence.
// ----------------------------------------------------------------------------
module bop_datapath
   import bop_pkg::*;
#(
   parameter int MAX_STEPS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  logic [31:0] spot_price,
   input  logic [31:0] strike_price,
   input  logic        is_call,
   input  logic        early_exercise,
   input  logic [31:0] up_factor,
   input  logic [31:0] down_factor,
   input  logic [30:0] up_probability,
   input  logic [30:0] step_discount,
   output logic [31:0] root_value,
   output logic        overflow
);

   localparam int AW = $clog2(MAX_STEPS + 1);

   logic [31:0] up_mem   [MAX_STEPS + 1];
   logic [31:0] down_mem [MAX_STEPS + 1];
   logic [31:0] node_mem [MAX_STEPS + 1];

   // captured beat
   logic [31:0] spot_ff, strike_ff, up_ff, down_ff, p_ff, q_ff, disc_ff;
   logic        call_ff, amer_ff;
   logic        ov_ff, ov_in;

   // sequence phase within a node
   logic [2:0]  ph_ff, ph_in;
   logic [31:0] upw_ff, dnw_ff, v0_ff, v1_ff, a_ff, b_ff, pr_ff;
   logic [63:0] e_ff;
   logic [31:0] root_ff;

   logic [AW-1:0] ia, ib, ic;
   logic [32:0]   m0, m1;
   logic [30:0]   p_sat, d_sat;

   // power steps read the down table at the same index as the up table
   assign ia = cmd.idx[AW-1:0];
   assign ib = (cmd.op == OP_POW) ? cmd.idx[AW-1:0] : AW'(cmd.lvl - cmd.idx);
   assign ic = AW'(cmd.idx + 13'd1);
   assign p_sat = (up_probability > 31'(ONE_Q30)) ? 31'(ONE_Q30) : up_probability;
   assign d_sat = (step_discount > 31'(ONE_Q30)) ? 31'(ONE_Q30) : step_discount;

   // memory reads, registered
   always_ff @(posedge clock) begin
      upw_ff <= up_mem[ia];
      dnw_ff <= down_mem[ib];
      v0_ff  <= node_mem[ia];
      v1_ff  <= node_mem[ic];
   end

   // sequence: first read, ph1 operands / e=p*v1, ph2 m=spot*up / e+=q*v0, ph3 m*down / e>>30*disc, ph4 write
   always_comb begin
      ph_in = ph_ff;
      ov_in = ov_ff;
      m0 = mul_q30(a_ff, b_ff);
      m1 = mul_q30(pr_ff, dnw_ff);
      stat.node_done = 1'b0;
      case (cmd.op)
         OP_LOAD: begin
            ph_in = 3'd0;
            ov_in = 1'b0;
         end
         OP_POW, OP_TERM, OP_BACK: begin
            if (cmd.first) ph_in = 3'd1;
            else ph_in = ph_ff + 3'd1;
            if (ph_ff == 3'd4 && !cmd.first) stat.node_done = 1'b1;
            // saturation flag: powers always, node prices only where formed
            if (cmd.op == OP_POW || cmd.op == OP_TERM || amer_ff) begin
               if (ph_ff == 3'd2 && m0[32]) ov_in = 1'b1;
               if (ph_ff == 3'd3 && ((cmd.op == OP_POW) ? m0[32] : m1[32])) ov_in = 1'b1;
            end
         end
         default: ph_in = 3'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= 3'd0;
         ov_ff <= 1'b0;
      end else begin
         ph_ff <= ph_in;
         ov_ff <= ov_in;
      end
   end

   // arithmetic and writeback
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            spot_ff <= spot_price;  strike_ff <= strike_price;
            call_ff <= is_call;     amer_ff <= early_exercise;
            up_ff <= up_factor;     down_ff <= down_factor;
            p_ff <= 32'(p_sat);     q_ff <= ONE_Q30 - 32'(p_sat);
            disc_ff <= 32'(d_sat);
            up_mem[0] <= ONE_Q30;   down_mem[0] <= ONE_Q30;
         end
         OP_POW: begin
            // power[idx+1] = power[idx] * factor, read at idx
            if (ph_ff == 3'd1 && !cmd.first) begin
               a_ff <= upw_ff; b_ff <= up_ff; pr_ff <= up_ff;
            end
            if (ph_ff == 3'd2) begin
               up_mem[ia + AW'(1)] <= m0[31:0];
               a_ff <= dnw_ff; b_ff <= down_ff;
            end
            if (ph_ff == 3'd3) begin
               down_mem[ia + AW'(1)] <= m0[31:0];
            end
         end
         OP_TERM, OP_BACK: begin
            if (ph_ff == 3'd1 && !cmd.first) begin
               a_ff <= spot_ff; b_ff <= upw_ff;
               e_ff <= 64'(p_ff) * 64'(v1_ff);
            end
            if (ph_ff == 3'd2) begin
               pr_ff <= m0[31:0];
               e_ff <= e_ff + 64'(q_ff) * 64'(v0_ff);
            end
            if (ph_ff == 3'd3) begin
               pr_ff <= payoff(m1[31:0], strike_ff, call_ff);
               e_ff <= (64'(e_ff[63:30]) * 64'(disc_ff)) >> 30;
            end
            if (ph_ff == 3'd4) begin
               if (cmd.op == OP_TERM) node_mem[ia] <= pr_ff;
               else if (amer_ff && pr_ff > e_ff[31:0]) node_mem[ia] <= pr_ff;
               else node_mem[ia] <= e_ff[31:0];
               if (cmd.idx == 13'd0) begin
                  if (cmd.op == OP_TERM) root_ff <= pr_ff;
                  else if (amer_ff && pr_ff > e_ff[31:0]) root_ff <= pr_ff;
                  else root_ff <= e_ff[31:0];
               end
            end
         end
         default: ;
      endcase
   end

   assign root_value = root_ff;
   assign overflow   = ov_ff;

endmodule

// ===== hdl/bop_control.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bop_control : sequencer of the binomial option pricer
// Walks powers, the terminal layer and every induction layer, then strobes.
// ----------------------------------------------------------------------------
module bop_control
   import bop_pkg::*;
#(
   parameter int MAX_STEPS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [10:0] steps,
   output cmd_type     cmd,
   input  stat_type    stat,
   output logic        rsp_valid
);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001, S_POW = 6'b000010, S_TERM = 6'b000100,
      S_BACK = 6'b001000, S_DONE = 6'b010000, S_LOAD = 6'b100000
   } state_type;

   state_type   st_ff, st_in;
   logic [12:0] n_ff, n_in, i_ff, i_in, t_ff, t_in;
   logic        first_ff, first_in;

   always_comb begin
      st_in = st_ff;
      n_in = n_ff; i_in = i_ff; t_in = t_ff; first_in = 1'b0;
      cmd.op = OP_NONE; cmd.idx = i_ff; cmd.lvl = t_ff; cmd.first = first_ff;
      case (st_ff)
         // the beat is captured at the accepting edge
         S_IDLE: if (start) begin
            cmd.op = OP_LOAD;
            st_in = S_LOAD;
            n_in = (13'(steps) > 13'(MAX_STEPS)) ? 13'(MAX_STEPS) : 13'(steps);
         end
         S_LOAD: begin
            i_in = 13'd0; first_in = 1'b1;
            st_in = (n_ff == 13'd0) ? S_TERM : S_POW;
            t_in = n_ff;
         end
         S_POW: begin
            cmd.op = OP_POW;
            if (stat.node_done) begin
               first_in = 1'b1;
               if (i_ff + 13'd1 == n_ff) begin
                  i_in = 13'd0; st_in = S_TERM;
               end else i_in = i_ff + 13'd1;
            end
         end
         S_TERM: begin
            cmd.op = OP_TERM;
            if (stat.node_done) begin
               first_in = 1'b1;
               if (i_ff == n_ff) begin
                  i_in = 13'd0;
                  if (n_ff == 13'd0) st_in = S_DONE;
                  else begin t_in = n_ff - 13'd1; st_in = S_BACK; end
               end else i_in = i_ff + 13'd1;
            end
         end
         S_BACK: begin
            cmd.op = OP_BACK;
            if (stat.node_done) begin
               first_in = 1'b1;
               if (i_ff == t_ff) begin
                  i_in = 13'd0;
                  if (t_ff == 13'd0) st_in = S_DONE;
                  else t_in = t_ff - 13'd1;
               end else i_in = i_ff + 13'd1;
            end
         end
         S_DONE: st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; n_ff <= '0; i_ff <= '0; t_ff <= '0; first_ff <= 1'b0;
      end else begin
         st_ff <= st_in; n_ff <= n_in; i_ff <= i_in; t_ff <= t_in; first_ff <= first_in;
      end
   end

   assign busy      = (st_ff != S_IDLE);
   assign rsp_valid = (st_ff == S_DONE);

endmodule

// ===== hdl/binomial_option_pricer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binomial_option_pricer : fixed-point binomial lattice option pricer
// One option per start beat; the root value is strobed once on rsp_valid.
// ----------------------------------------------------------------------------
// Each node (power, terminal or induction) runs through one shared
// registered multiply sequence and registered lattice reads, one node at a
// time; an item works N powers, N+1 terminal nodes and N(N+1)/2 induction
// nodes for N = tree_steps (capped at MAX_STEPS), between a load state and the
// result state. The beat is captured at the accepting edge. busy is high for
// the whole item; the result beat cannot be stalled and is shown for exactly
// one cycle.
module binomial_option_pricer
   import bop_pkg::*;
#(
   parameter int MAX_STEPS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_spot_price,
   input  logic [31:0] req_strike_price,
   input  logic        req_is_call,
   input  logic        req_early_exercise,
   input  logic [31:0] req_up_factor,
   input  logic [31:0] req_down_factor,
   input  logic [30:0] req_up_probability,
   input  logic [30:0] req_step_discount,
   output logic        rsp_valid,
   output logic [31:0] rsp_option_value,
   output logic        rsp_overflow,
   input  logic        csr_write,
   input  logic [10:0] csr_wdata
);

   logic [10:0] steps_ff;
   cmd_type     cmd;
   stat_type    stat;

   // tree_steps register
   always_ff @(posedge clock) begin
      if (reset) steps_ff <= STEPS_RESET;
      else if (csr_write) steps_ff <= csr_wdata;
   end

   bop_control #(.MAX_STEPS(MAX_STEPS)) u_ctl (
      .clock, .reset, .start, .busy, .steps(steps_ff), .cmd, .stat, .rsp_valid
   );

   bop_datapath #(.MAX_STEPS(MAX_STEPS)) u_dp (
      .clock, .reset, .cmd, .stat,
      .spot_price(req_spot_price), .strike_price(req_strike_price),
      .is_call(req_is_call), .early_exercise(req_early_exercise),
      .up_factor(req_up_factor), .down_factor(req_down_factor),
      .up_probability(req_up_probability), .step_discount(req_step_discount),
      .root_value(rsp_option_value), .overflow(rsp_overflow)
   );

endmodule

// ===== hdl/bop_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bop_checker : port-level checks on the binomial option pricer
// Strobe and busy relationships seen at the top level.
// ----------------------------------------------------------------------------
module bop_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // a result beat only ends an item in flight
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result strobe while idle");

   // strobe lasts one cycle
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe held");

   // accepted beat makes the block busy
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("start not taken");

   // busy falls only after a result beat
   a_busy_end: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> $past(rsp_valid)) else $error("item dropped");

endmodule

bind binomial_option_pricer bop_checker u_bop_checker (
   .clock, .reset, .start, .busy, .rsp_valid
);

// ===== test/binomial_option_pricer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binomial_option_pricer_tb : self-checking bench for the lattice pricer
// Drives option beats through the start/busy handshake and checks each root
// value and overflow flag against a bit-true lattice predictor in the bench or a typed value.
// ----------------------------------------------------------------------------
module binomial_option_pricer_tb
   import bop_pkg::*;
();

   localparam int  LATTICE_MAX = 1024;
   localparam longint CYCLE_LIMIT = 20_000_000;

   typedef struct {
      logic [31:0] spot;
      logic [31:0] strike;
      logic        call;
      logic        american;
      logic [31:0] up;
      logic [31:0] down;
      logic [30:0] prob;
      logic [30:0] disc;
      bit          typed;     // expected value typed into the table
      logic [31:0] want_val;
      logic        want_ov;
   } option_type;

   typedef struct {
      logic [31:0] val;
      logic        ov;
   } price_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [31:0] req_spot_price = '0;
   logic [31:0] req_strike_price = '0;
   logic        req_is_call = 1'b0;
   logic        req_early_exercise = 1'b0;
   logic [31:0] req_up_factor = '0;
   logic [31:0] req_down_factor = '0;
   logic [30:0] req_up_probability = '0;
   logic [30:0] req_step_discount = '0;
   logic        rsp_valid;
   logic [31:0] rsp_option_value;
   logic        rsp_overflow;
   logic        csr_write = 1'b0;
   logic [10:0] csr_wdata = '0;

   logic [10:0] steps_reg = STEPS_RESET;
   price_type   pending_prices[$];
   int          fail_count = 0;
   longint      cycles = 0;
   bit          calm = 0;
   option_type  dir_tab[$];

   binomial_option_pricer u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_spot_price(req_spot_price), .req_strike_price(req_strike_price),
      .req_is_call(req_is_call), .req_early_exercise(req_early_exercise),
      .req_up_factor(req_up_factor), .req_down_factor(req_down_factor),
      .req_up_probability(req_up_probability), .req_step_discount(req_step_discount),
      .rsp_valid(rsp_valid), .rsp_option_value(rsp_option_value),
      .rsp_overflow(rsp_overflow), .csr_write(csr_write), .csr_wdata(csr_wdata)
   );

   // clock, 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run-away guard
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic report(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      fail_count++;
   endtask

   // truncating Q30 product, bit 32 flags saturation
   function automatic logic [32:0] fx_mul(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] r;
      r = ({32'd0, a} * {32'd0, b}) >> 30;
      if (r > 64'hFFFF_FFFF) return {1'b1, 32'hFFFF_FFFF};
      return {1'b0, r[31:0]};
   endfunction

   function automatic logic [31:0] intrinsic(input logic [31:0] pr, input logic [31:0] k,
                                             input logic call);
      if (call) return (pr > k) ? pr - k : 32'd0;
      return (k > pr) ? k - pr : 32'd0;
   endfunction

   // root value of the lattice for one option at the given step count
   function automatic price_type lattice_root(input option_type o, input logic [10:0] steps);
      logic [31:0] upw[0:LATTICE_MAX];
      logic [31:0] dnw[0:LATTICE_MAX];
      logic [31:0] vals[0:LATTICE_MAX];
      logic [32:0] m;
      logic [31:0] p, q, d, hold, ex;
      logic [63:0] e;
      int          n;
      price_type   res;
      res.ov = 1'b0;
      n = (steps > LATTICE_MAX) ? LATTICE_MAX : steps;
      p = (o.prob > ONE_Q30) ? ONE_Q30 : {1'b0, o.prob};
      d = (o.disc > ONE_Q30) ? ONE_Q30 : {1'b0, o.disc};
      q = ONE_Q30 - p;
      upw[0] = ONE_Q30;
      dnw[0] = ONE_Q30;
      for (int i = 1; i <= n; i++) begin
         m = fx_mul(upw[i-1], o.up);   upw[i] = m[31:0]; res.ov |= m[32];
         m = fx_mul(dnw[i-1], o.down); dnw[i] = m[31:0]; res.ov |= m[32];
      end
      // terminal layer
      for (int i = 0; i <= n; i++) begin
         m = fx_mul(o.spot, upw[i]);  res.ov |= m[32];
         m = fx_mul(m[31:0], dnw[n-i]); res.ov |= m[32];
         vals[i] = intrinsic(m[31:0], o.strike, o.call);
      end
      // backward induction
      for (int t = n - 1; t >= 0; t--) begin
         for (int i = 0; i <= t; i++) begin
            e = {32'd0, p} * {32'd0, vals[i+1]} + {32'd0, q} * {32'd0, vals[i]};
            e = ((e >> 30) * {32'd0, d}) >> 30;
            hold = e[31:0];
            if (o.american) begin
               m = fx_mul(o.spot, upw[i]);  res.ov |= m[32];
               m = fx_mul(m[31:0], dnw[t-i]); res.ov |= m[32];
               ex = intrinsic(m[31:0], o.strike, o.call);
               if (ex > hold) hold = ex;
            end
            vals[i] = hold;
         end
      end
      res.val = vals[0];
      return res;
   endfunction

   function automatic option_type mk(input logic [31:0] s, input logic [31:0] k,
                                     input logic c, input logic a,
                                     input logic [31:0] u, input logic [31:0] dn,
                                     input logic [30:0] p, input logic [30:0] ds);
      option_type o;
      o.spot = s; o.strike = k; o.call = c; o.american = a; o.up = u; o.down = dn;
      o.prob = p; o.disc = ds; o.typed = 0; o.want_val = '0; o.want_ov = 1'b0;
      return o;
   endfunction

   function automatic option_type typed_row(input option_type o, input logic [31:0] v,
                                            input logic ov);
      o.typed = 1; o.want_val = v; o.want_ov = ov;
      return o;
   endfunction

   // well-formed option with random content, or raw noise
   function automatic option_type random_option();
      option_type o;
      if ($urandom_range(0, 4) == 0) begin
         o = mk($urandom, $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                $urandom, $urandom, 31'($urandom), 31'($urandom));
      end else begin
         o = mk($urandom_range(32'h0001_0000, 32'h00C8_0000),
                $urandom_range(32'h0001_0000, 32'h00C8_0000),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                ONE_Q30 + $urandom_range(0, 32'h0C00_0000),
                ONE_Q30 - $urandom_range(0, 32'h0C00_0000),
                31'($urandom_range(0, ONE_Q30)),
                31'(ONE_Q30 - $urandom_range(0, 32'h0100_0000)));
      end
      return o;
   endfunction

   // result beats: compare with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_prices.size() == 0) begin
            report($sformatf("unexpected beat value=%h ov=%b", rsp_option_value,
                             rsp_overflow));
         end else begin
            price_type w;
            w = pending_prices.pop_front();
            if (rsp_option_value !== w.val)
               report($sformatf("option_value got %h want %h", rsp_option_value, w.val));
            if (rsp_overflow !== w.ov)
               report($sformatf("overflow got %b want %b", rsp_overflow, w.ov));
         end
      end
   end

   // one option beat, with an optional idle burst in front
   task automatic send_option(input option_type o);
      price_type w;
      if (!calm && $urandom_range(0, 2) == 0) begin
         start = 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      start = 1'b1;
      req_spot_price = o.spot;     req_strike_price = o.strike;
      req_is_call = o.call;        req_early_exercise = o.american;
      req_up_factor = o.up;        req_down_factor = o.down;
      req_up_probability = o.prob; req_step_discount = o.disc;
      do @(posedge clock); while (busy);
      if (o.typed) begin
         w.val = o.want_val;
         w.ov = o.want_ov;
      end else begin
         w = lattice_root(o, steps_reg);
      end
      pending_prices.push_back(w);
      @(negedge clock);
   endtask

   // let the block drain, then change the step count
   task automatic set_steps(input logic [10:0] v);
      start = 1'b0;
      while (pending_prices.size() != 0 || busy) @(negedge clock);
      repeat (5) @(negedge clock);
      csr_write = 1'b1;
      csr_wdata = v;
      @(negedge clock);
      csr_write = 1'b0;
      steps_reg = v;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset step count
      send_option(mk(32'h0064_0000, 32'h0064_0000, 1'b0, 1'b1, 32'h4100_0000,
                     32'h3F00_0000, 31'h2000_0000, 31'h3FF0_0000));

      // zero steps: root is the payoff at the spot
      set_steps(11'd0);
      dir_tab.push_back(typed_row(mk(32'd10, 32'd3, 1'b1, 1'b0, '0, '0, '0, '0), 32'd7, 1'b0));
      dir_tab.push_back(typed_row(mk(32'd10, 32'd3, 1'b0, 1'b1, '1, '1, '1, '1), 32'd0, 1'b0));
      dir_tab.push_back(typed_row(mk(32'd3, 32'd10, 1'b0, 1'b0, '0, '0, '0, '0), 32'd7, 1'b0));
      dir_tab.push_back(typed_row(mk('1, '0, 1'b1, 1'b1, '0, '0, '0, '0), '1, 1'b0));
      dir_tab.push_back(typed_row(mk('0, '1, 1'b0, 1'b0, '1, '1, '1, '1), '1, 1'b0));
      dir_tab.push_back(typed_row(mk('1, '1, 1'b1, 1'b0, '0, '0, '0, '0), '0, 1'b0));
      foreach (dir_tab[i]) send_option(dir_tab[i]);
      dir_tab.delete();

      // small lattice: modes, probability/discount above one, saturation
      set_steps(11'd3);
      dir_tab.push_back(mk(32'h0064_0000, 32'h0064_0000, 1'b1, 1'b0, 32'h4400_0000,
                           32'h3C00_0000, 31'h2000_0000, 31'h3F00_0000));
      dir_tab.push_back(mk(32'h0064_0000, 32'h0064_0000, 1'b1, 1'b1, 32'h4400_0000,
                           32'h3C00_0000, 31'h2000_0000, 31'h3F00_0000));
      dir_tab.push_back(mk(32'h0064_0000, 32'h0070_0000, 1'b0, 1'b0, 32'h4400_0000,
                           32'h3C00_0000, 31'h2000_0000, 31'h3F00_0000));
      dir_tab.push_back(mk(32'h0064_0000, 32'h0070_0000, 1'b0, 1'b1, 32'h4400_0000,
                           32'h3C00_0000, 31'h2000_0000, 31'h3F00_0000));
      dir_tab.push_back(mk(32'h0064_0000, 32'h0050_0000, 1'b1, 1'b1, 32'h4400_0000,
                           32'h3C00_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF));
      dir_tab.push_back(mk(32'h0064_0000, 32'h0050_0000, 1'b0, 1'b0, 32'h4400_0000,
                           32'h3C00_0000, 31'h4000_0001, 31'h0));
      dir_tab.push_back(mk('1, 32'h0001_0000, 1'b1, 1'b0, '1, '1, 31'h2000_0000,
                           31'h4000_0000));
      dir_tab.push_back(mk('1, 32'h0001_0000, 1'b1, 1'b1, '1, 32'h0, 31'h4000_0000,
                           31'h4000_0000));
      dir_tab.push_back(mk(32'h0064_0000, '1, 1'b0, 1'b1, 32'h0, '1, 31'h1000_0000,
                           31'h3FFF_FFFF));
      foreach (dir_tab[i]) send_option(dir_tab[i]);

      // one step, then the capped maximum
      set_steps(11'd1);
      send_option(dir_tab[1]);
      send_option(dir_tab[3]);
      set_steps(11'h7FF);
      send_option(dir_tab[3]);
      dir_tab.delete();

      // random phases at small step counts
      for (int ph = 0; ph < 10; ph++) begin
         set_steps(11'($urandom_range(1, 12)));
         for (int k = 0; k < 10; k++) begin
            calm = (ph == 9);
            send_option(random_option());
         end
         if (ph == 4) begin
            // hold off until everything is back
            start = 1'b0;
            while (pending_prices.size() != 0) @(negedge clock);
         end
      end

      start = 1'b0;
      while (pending_prices.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
